FILE: hw/rtl/lex_combination_walk_and_unrank_assert.svh
// Assertion macros for the combination walker
`ifndef LEX_COMBINATION_WALK_AND_UNRANK_ASSERT_SVH
`define LEX_COMBINATION_WALK_AND_UNRANK_ASSERT_SVH
`define LCW_ASSERT_IMPL(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define LCW_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

FILE: hw/rtl/lcw_pkg.sv
// ---------------------------------------------------------------------------
// lcw_pkg
// Types, constants and the binomial function of the combination walker.
// ---------------------------------------------------------------------------
`default_nettype none
package lcw_pkg;
	localparam int DEF_MAX_ELEMENTS = 32;
	localparam int DEF_MAX_LENGTH = 8;
	localparam int RANK_W = 24;
	localparam int CFG_W = 6;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_N = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_K = 1'd1;
	localparam logic [1:0] MODE_NEXT = 2'd0;
	localparam logic [1:0] MODE_PREV = 2'd1;
	localparam logic [1:0] MODE_JUMP = 2'd2;

	typedef struct packed {
		logic [1:0]        mode;
		logic [RANK_W-1:0] jump_index;
	} cmd_t;

	typedef struct packed {
		logic [2:0]        slot;
		logic [4:0]        element_position;
		logic [RANK_W-1:0] combination_rank;
		logic              out_of_range;
		logic              last;
	} res_t;

	// Binomial saturated at 2^24; constant-table style, table index a,b narrow.
	function automatic logic [RANK_W:0] binom_sat(input logic [6:0] a, input logic [4:0] b);
		logic [63:0] r;
		r = 64'd1;
		if (b > a) return '0;
		for (int i = 0; i < 16; i++) begin
			if (i < b) r = r * 64'(a - i) / 64'(i + 1);
		end
		if (r > 64'(1 << RANK_W)) r = 64'(1 << RANK_W);
		return r[RANK_W:0];
	endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/lex_combination_walk_and_unrank.sv
// ---------------------------------------------------------------------------
// lex_combination_walk_and_unrank
// Lexicographic k-of-n combination walker with next, previous and unranking.
// ---------------------------------------------------------------------------
// After reset or a config write, a restart sweep sums the binomial table into C(n,k).
// Next: scan of up to k slots (SCAN, SCANW each); prev: SCAN, PRD, PRW per slot; then FILL for slots s..k-1.
// Jump: ST_JWALK steps through candidate values (binomial table), at most n values in all.
// Then ORD and ORW per slot, one result strobe each; busy falls after the last strobe cycle.
// One command at a time; receiver cannot stall.
// Reset is asynchronous; positions restart at 0..k-1 and rank at zero.
`default_nettype none
module lex_combination_walk_and_unrank import lcw_pkg::*; #(
	parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
	parameter int MAX_LENGTH = DEF_MAX_LENGTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire cmd_t                 cmd,
	output logic                      result_valid,
	output res_t                      result,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);
	localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int SW = AW + 1;
	localparam int PW = 7;
	localparam int TAW = $clog2(MAX_ELEMENTS);
	localparam int CLR_LEN = (MAX_ELEMENTS > MAX_LENGTH) ? MAX_ELEMENTS : MAX_LENGTH;
	localparam logic [RANK_W:0] RANK_SAT = {1'b1, {RANK_W{1'b0}}};

	localparam logic [3:0] ST_CLR = 4'd0, ST_IDLE = 4'd1, ST_SCAN = 4'd2,
		ST_SCANW = 4'd3, ST_FILL = 4'd4, ST_JRD = 4'd5, ST_JRW = 4'd6,
		ST_JWALK = 4'd7, ST_ORD = 4'd8, ST_ORW = 4'd9, ST_OUT = 4'd10,
		ST_PRD = 4'd11, ST_PRW = 4'd12;

	logic [3:0] st_q;
	logic [5:0] ncfg_q;
	logic [3:0] kcfg_q;
	logic [RANK_W-1:0] rank_q, tgt_q, rem_q;
	logic [1:0] mode_q;
	logic oor_q;
	logic [SW-1:0] s_q;
	logic [PW-1:0] v_q, cur_q, c_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [4:0] wdata, rdata;

	lcw_ram #(.WIDTH(5), .DEPTH(1 << AW)) u_pos (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// effective sizes
	logic [PW-1:0] n_eff;
	logic [SW:0] k_eff;
	always_comb begin
		n_eff = (ncfg_q == 6'd0) ? PW'(1) : PW'(ncfg_q);
		if (n_eff > PW'(MAX_ELEMENTS)) n_eff = PW'(MAX_ELEMENTS);
		k_eff = (kcfg_q == 4'd0) ? (SW+1)'(1) : (SW+1)'(kcfg_q);
		if (k_eff > (SW+1)'(MAX_LENGTH)) k_eff = (SW+1)'(MAX_LENGTH);
		if (PW'(k_eff) > n_eff) k_eff = (SW+1)'(n_eff);
	end

	// constant binomial table C(a,b), a < MAX_ELEMENTS, b < MAX_LENGTH
	logic [RANK_W:0] btab [MAX_ELEMENTS][MAX_LENGTH];
	for (genvar ga = 0; ga < MAX_ELEMENTS; ga++) begin : g_row
		for (genvar gb = 0; gb < MAX_LENGTH; gb++) begin : g_col
			assign btab[ga][gb] = binom_sat(7'(ga), 5'(gb));
		end
	end

	logic [RANK_W:0] count_q;
	logic [RANK_W:0] blk;
	logic [PW-1:0] tail;
	logic [PW-1:0] top_s;
	logic [TAW-1:0] tab_a;
	logic [AW-1:0] tab_b;
	logic [RANK_W+1:0] cnt_sum;
	logic [RANK_W:0] cnt_sum_sat;
	assign tail = PW'(k_eff) - PW'(s_q) - PW'(1);
	assign top_s = n_eff - PW'(k_eff) + PW'(s_q);

	// sweep sums column k-1 over rows 0..n-1 (hockey stick) for C(n,k)
	always_comb begin
		if (st_q == ST_CLR) begin
			tab_a = TAW'(c_q);
			tab_b = AW'(k_eff - 1);
		end else begin
			tab_a = TAW'(n_eff - PW'(1) - v_q);
			tab_b = AW'(tail);
		end
	end
	assign blk = btab[tab_a][tab_b];
	assign cnt_sum = {1'b0, count_q} + {1'b0, blk};
	assign cnt_sum_sat = (cnt_sum > {1'b0, RANK_SAT}) ? RANK_SAT : cnt_sum[RANK_W:0];

	assign busy = (st_q != ST_IDLE);

	always_comb begin
		we = 1'b0; waddr = s_q[AW-1:0]; wdata = cur_q[4:0]; raddr = s_q[AW-1:0];
		case (st_q)
			ST_CLR: begin
				we = (c_q < PW'(MAX_LENGTH)); waddr = c_q[AW-1:0]; wdata = c_q[4:0];
			end
			ST_FILL: begin we = 1'b1; wdata = v_q[4:0]; end
			ST_JWALK: begin
				we = (v_q >= n_eff - tail) || ({1'b0, rem_q} < blk);
				wdata = v_q[4:0];
			end
			ST_PRD, ST_JRD: raddr = AW'(s_q - SW'(1));
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR; ncfg_q <= 6'd32; kcfg_q <= 4'd8; rank_q <= '0;
			s_q <= '0; c_q <= '0; count_q <= '0; result_valid <= 1'b0; result <= '0;
			mode_q <= '0; oor_q <= 1'b0;
			tgt_q <= '0; rem_q <= '0; v_q <= '0; cur_q <= '0;
		end else begin
			result_valid <= (st_q == ST_ORW) && !cfg_we;
			if (cfg_we) begin
				// any register write restarts the walk
				if (cfg_index == REG_N) ncfg_q <= cfg_data;
				else kcfg_q <= cfg_data[3:0];
				c_q <= '0; count_q <= '0; s_q <= '0; st_q <= ST_CLR;
			end else begin
				case (st_q)
					ST_CLR: begin
						rank_q <= '0;
						if (c_q < n_eff) count_q <= cnt_sum_sat;
						if (c_q == PW'(CLR_LEN - 1)) begin c_q <= '0; st_q <= ST_IDLE; end
						else c_q <= c_q + PW'(1);
					end
					ST_IDLE: begin
						if (start) begin
							mode_q <= cmd.mode; tgt_q <= cmd.jump_index;
							case (cmd.mode)
								MODE_NEXT: begin
									if ({1'b0, rank_q} + 25'd1 >= count_q) begin
										oor_q <= 1'b1; s_q <= '0; st_q <= ST_ORD;
									end else begin
										oor_q <= 1'b0; s_q <= SW'(k_eff - 1); st_q <= ST_SCAN;
									end
								end
								MODE_PREV: begin
									if (rank_q == '0) begin
										oor_q <= 1'b1; s_q <= '0; st_q <= ST_ORD;
									end else begin
										oor_q <= 1'b0; s_q <= SW'(k_eff - 1); st_q <= ST_SCAN;
									end
								end
								MODE_JUMP: begin
									if ({1'b0, cmd.jump_index} >= count_q) begin
										oor_q <= 1'b1; s_q <= '0; st_q <= ST_ORD;
									end else begin
										oor_q <= 1'b0; rem_q <= cmd.jump_index; v_q <= '0;
										s_q <= '0; st_q <= ST_JWALK;
									end
								end
								default: begin oor_q <= 1'b1; s_q <= '0; st_q <= ST_ORD; end
							endcase
						end
					end
					ST_SCAN: st_q <= (mode_q == MODE_PREV) ? ST_PRD : ST_SCANW;
					ST_SCANW: begin
						if (PW'(rdata) < top_s) begin
							v_q <= PW'(rdata) + PW'(1); st_q <= ST_FILL;
							rank_q <= rank_q + RANK_W'(1);
						end else begin s_q <= s_q - SW'(1); st_q <= ST_SCAN; end
					end
					ST_PRD: begin cur_q <= PW'(rdata); st_q <= ST_PRW; end
					ST_PRW: begin
						// rdata now holds previous slot; floor is it plus one
						if (cur_q > ((s_q == '0) ? PW'(0) : PW'(rdata) + PW'(1))) begin
							v_q <= cur_q - PW'(1); st_q <= ST_FILL;
							rank_q <= rank_q - RANK_W'(1);
						end else begin s_q <= s_q - SW'(1); st_q <= ST_SCAN; end
					end
					ST_FILL: begin
						if (PW'(s_q) + PW'(1) >= PW'(k_eff)) begin s_q <= '0; st_q <= ST_ORD; end
						else begin
							s_q <= s_q + SW'(1);
							v_q <= (mode_q == MODE_PREV) ? n_eff - PW'(k_eff) + PW'(s_q) + PW'(1)
								: v_q + PW'(1);
						end
					end
					ST_JWALK: begin
						if (we) begin
							if (PW'(s_q) + PW'(1) >= PW'(k_eff)) begin
								rank_q <= tgt_q; s_q <= '0; st_q <= ST_ORD;
							end else begin s_q <= s_q + SW'(1); v_q <= v_q + PW'(1); end
						end else begin
							rem_q <= rem_q - blk[RANK_W-1:0]; v_q <= v_q + PW'(1);
						end
					end
					ST_ORD: st_q <= ST_ORW;
					ST_ORW: begin
						result.slot <= 3'(s_q);
						result.element_position <= rdata;
						result.combination_rank <= rank_q;
						result.out_of_range <= oor_q;
						result.last <= (PW'(s_q) + PW'(1) == PW'(k_eff));
						if (PW'(s_q) + PW'(1) == PW'(k_eff)) st_q <= ST_OUT;
						else begin s_q <= s_q + SW'(1); st_q <= ST_ORD; end
					end
					ST_OUT: begin s_q <= '0; st_q <= ST_IDLE; end
					default: st_q <= ST_IDLE;
				endcase
			end
		end
	end

	`include "lex_combination_walk_and_unrank_assert.svh"
	`LCW_ASSERT_IMPL(a_busy_on_res, result_valid, busy)
	`LCW_ASSERT_NEXT(a_start_busy, start && !busy && !(cfg_we), busy)
	`LCW_ASSERT_IMPL(a_rank_ok, !busy, {1'b0, rank_q} < count_q || count_q == '0)
endmodule
`default_nettype wire

FILE: hw/rtl/lcw_ram.sv
// ---------------------------------------------------------------------------
// lcw_ram
// Generic single-port-write, single-read RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module lcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: verif/lex_combination_walk_and_unrank_tb.sv
// ---------------------------------------------------------------------------
// lex_combination_walk_and_unrank_tb
// Drives next, previous and jump commands into the combination walker at
// several n/k settings, predicts the slot results and checks them in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

class comb_walk_scoreboard;
	logic [5:0] n_reg;
	logic [3:0] k_reg;
	int unsigned positions[8];
	int unsigned rank;
	lcw_pkg::res_t pending[$];
	int fails;

	function new();
		fails = 0;
		n_reg = 6'd32;
		k_reg = 4'd8;
		restart();
	endfunction

	function int unsigned n_eff();
		int unsigned n;
		n = n_reg;
		if (n < 1) n = 1;
		if (n > 32) n = 32;
		return n;
	endfunction

	function int unsigned k_eff();
		int unsigned k;
		k = k_reg;
		if (k < 1) k = 1;
		if (k > 8) k = 8;
		if (k > n_eff()) k = n_eff();
		return k;
	endfunction

	function longint unsigned choose(int unsigned a, int unsigned b);
		longint unsigned r;
		r = 1;
		if (b > a) return 0;
		for (int unsigned i = 0; i < b; i++)
			r = r * (a - i) / (i + 1);
		return r;
	endfunction

	function int unsigned rank_count();
		longint unsigned c;
		c = choose(n_eff(), k_eff());
		if (c > 64'h100_0000) c = 64'h100_0000;
		return int'(c);
	endfunction

	function void restart();
		for (int unsigned i = 0; i < 8; i++)
			positions[i] = (i < k_eff()) ? i : 0;
		rank = 0;
	endfunction

	function void write_reg(logic idx, logic [5:0] data);
		if (idx == lcw_pkg::REG_N) n_reg = data;
		else k_reg = data[3:0];
		restart();
	endfunction

	function void advance(int unsigned n, int unsigned k);
		for (int s = int'(k) - 1; s >= 0; s--) begin
			if (positions[s] < n - k + s) begin
				positions[s]++;
				for (int unsigned j = s + 1; j < k; j++) positions[j] = positions[j-1] + 1;
				return;
			end
		end
	endfunction

	function void retreat(int unsigned n, int unsigned k);
		int unsigned floor_v;
		for (int s = int'(k) - 1; s >= 0; s--) begin
			floor_v = (s == 0) ? 0 : positions[s-1] + 1;
			if (positions[s] > floor_v) begin
				positions[s]--;
				for (int unsigned j = s + 1; j < k; j++) positions[j] = n - k + j;
				return;
			end
		end
	endfunction

	function void unrank(int unsigned n, int unsigned k, int unsigned target);
		longint unsigned remain, blk;
		int unsigned v, tail;
		remain = target;
		for (int unsigned s = 0; s < k; s++) begin
			v = (s == 0) ? 0 : positions[s-1] + 1;
			tail = k - s - 1;
			while (v < n - tail) begin
				blk = choose(n - 1 - v, tail);
				if (remain < blk) break;
				remain -= blk;
				v++;
			end
			positions[s] = v;
		end
	endfunction

	function void note_command(lcw_pkg::cmd_t c);
		int unsigned n, k, cnt;
		logic refused;
		lcw_pkg::res_t r;
		n = n_eff();
		k = k_eff();
		cnt = rank_count();
		refused = 1'b0;
		case (c.mode)
			lcw_pkg::MODE_NEXT: begin
				if (rank + 1 >= cnt) refused = 1'b1;
				else begin
					advance(n, k);
					rank++;
				end
			end
			lcw_pkg::MODE_PREV: begin
				if (rank == 0) refused = 1'b1;
				else begin
					retreat(n, k);
					rank--;
				end
			end
			lcw_pkg::MODE_JUMP: begin
				if (c.jump_index >= cnt) refused = 1'b1;
				else begin
					unrank(n, k, c.jump_index);
					rank = c.jump_index;
				end
			end
			default: refused = 1'b1;
		endcase
		for (int unsigned s = 0; s < k; s++) begin
			r.slot = s[2:0];
			r.element_position = positions[s][4:0];
			r.combination_rank = rank[23:0];
			r.out_of_range = refused;
			r.last = (s + 1 == k);
			pending.insert(pending.size(), r);
		end
	endfunction

	function void check_result(lcw_pkg::res_t got);
		lcw_pkg::res_t exp_r;
		if (pending.size() == 0) begin
			$error("unexpected result transaction: %p", got);
			fails++;
			return;
		end
		exp_r = pending.pop_front();
		if (got.slot !== exp_r.slot) begin
			$error("slot: expected %0d, got %0d", exp_r.slot, got.slot);
			fails++;
		end
		if (got.element_position !== exp_r.element_position) begin
			$error("element_position: expected %0d, got %0d",
				exp_r.element_position, got.element_position);
			fails++;
		end
		if (got.combination_rank !== exp_r.combination_rank) begin
			$error("combination_rank: expected %0d, got %0d",
				exp_r.combination_rank, got.combination_rank);
			fails++;
		end
		if (got.out_of_range !== exp_r.out_of_range) begin
			$error("out_of_range: expected %0d, got %0d", exp_r.out_of_range, got.out_of_range);
			fails++;
		end
		if (got.last !== exp_r.last) begin
			$error("last: expected %0d, got %0d", exp_r.last, got.last);
			fails++;
		end
	endfunction
endclass

module lex_combination_walk_and_unrank_tb;
	import lcw_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic result_valid;
	res_t result;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	comb_walk_scoreboard walk_sb;
	int idle_cycles;
	int burst_left;

	lex_combination_walk_and_unrank i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.result_valid(result_valid),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// transaction monitor and stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) walk_sb.note_command(cmd);
			if (result_valid) walk_sb.check_result(result);
			if ((start && !busy) || result_valid) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic issue(logic [1:0] mode, logic [23:0] idx);
		start <= 1'b1;
		cmd <= '{mode: mode, jump_index: idx};
		@(posedge clk);
		while (busy) @(posedge clk);
		if (burst_left > 0) burst_left--;
		else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 6);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (walk_sb.pending.size() != 0 || busy) @(posedge clk);
		repeat (DEF_MAX_LENGTH + 4) @(posedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [5:0] data);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		walk_sb.write_reg(idx, data);
		cfg_we <= 1'b0;
		repeat (DEF_MAX_LENGTH + 4) @(posedge clk);
	endtask

	task automatic random_command();
		int unsigned cnt, pick;
		cnt = walk_sb.rank_count();
		pick = $urandom_range(0, 99);
		if (pick < 40) issue(MODE_NEXT, 24'($urandom));
		else if (pick < 65) issue(MODE_PREV, 24'($urandom));
		else if (pick < 80) issue(MODE_JUMP, 24'($urandom_range(0, cnt - 1)));
		else if (pick < 87) issue(MODE_JUMP, 24'(cnt - 1 - $urandom_range(0, 1)));
		else if (pick < 95) issue(MODE_JUMP, 24'($urandom));
		else issue(MODE_UNUSED, 24'($urandom));
	endtask

	initial begin
		logic [5:0] n_val, k_val;
		walk_sb = new();
		idle_cycles = 0;
		burst_left = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (DEF_MAX_LENGTH + 4) @(posedge clk);

		// directed: reset sizes, both ends of the rank range
		issue(MODE_PREV, 24'd0);
		issue(MODE_NEXT, 24'hFFFFFF);
		issue(MODE_JUMP, 24'd10518299);
		issue(MODE_NEXT, 24'd0);
		issue(MODE_PREV, 24'd0);
		issue(MODE_JUMP, 24'd10518300);
		issue(MODE_JUMP, 24'hFFFFFF);
		issue(MODE_UNUSED, 24'h123456);
		issue(MODE_JUMP, 24'd0);
		issue(MODE_JUMP, 24'd5000000);
		// single element, single slot
		write_cfg(REG_N, 6'd0);
		write_cfg(REG_K, 6'd0);
		issue(MODE_NEXT, 24'd0);
		issue(MODE_PREV, 24'd0);
		issue(MODE_JUMP, 24'd0);
		issue(MODE_JUMP, 24'd1);
		// oversized register values clamp, k larger than n clamps to n
		write_cfg(REG_N, 6'd63);
		write_cfg(REG_K, 6'd15);
		issue(MODE_JUMP, 24'd10518299);
		issue(MODE_PREV, 24'd0);
		write_cfg(REG_N, 6'd3);
		issue(MODE_NEXT, 24'd0);
		issue(MODE_JUMP, 24'd0);
		issue(MODE_PREV, 24'd0);

		for (int phase = 0; phase < 11; phase++) begin
			case (phase)
				0: begin n_val = 6'd32; k_val = 6'd8; end
				1: begin n_val = 6'd32; k_val = 6'd1; end
				2: begin n_val = 6'd2; k_val = 6'd1; end
				default: begin
					n_val = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(1, 10));
					k_val = 6'($urandom);
				end
			endcase
			write_cfg(REG_N, n_val);
			write_cfg(REG_K, k_val);
			for (int i = 0; i < 40; i++) random_command();
		end

		drain();
		if (walk_sb.fails == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end
endmodule

`default_nettype wire
